FILE: rtl/mpq_pkg.sv
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 7;

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_FIND    = 2'd1,
    FN_EXTRACT = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = '1;

  // Data a cell shows its neighbors.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    vld;
    logic                    gt;   // new key sorts at or before this cell
  } mpq_link_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    ext;
    logic signed [KEY_W-1:0] key;
  } mpq_cmd_t;

endpackage

FILE: rtl/mpq_req_if.sv
interface mpq_req_if;
  import mpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output func, output key_in, input ready);
  modport sink   (input valid, input func, input key_in, output ready);
endinterface

FILE: rtl/mpq_rsp_if.sv
interface mpq_rsp_if;
  import mpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic [1:0]              status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output key_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input key_out, input status, input occupancy,
                  output ready);
endinterface

FILE: rtl/mpq_cell.sv
module mpq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpq_pkg::mpq_cmd_t  cmd_i,
  input  mpq_pkg::mpq_link_t prev_i,
  input  mpq_pkg::mpq_link_t next_i,
  output mpq_pkg::mpq_link_t link_o
);
  import mpq_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    vld_q, vld_d;
  logic                    gt;

  assign gt = !vld_q || (cmd_i.key < key_q);

  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    if (cmd_i.ins && gt) begin
      if (prev_i.gt) begin
        // shift right: take the left neighbor's entry
        key_d = prev_i.key;
        vld_d = prev_i.vld;
      end else begin
        key_d = cmd_i.key;
        vld_d = 1'b1;
      end
    end else if (cmd_i.ext) begin
      key_d = next_i.key;
      vld_d = next_i.vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o = '{key: key_q, vld: vld_q, gt: gt};

endmodule

FILE: rtl/min_priority_queue.sv
// Channel  Dir  Payload                              Role
// req_i    in   func[1:0], key_in[31:0] signed       insert / find min / extract min
// rsp_o    out  key_out[31:0], status[1:0], occ[6:0] one beat per request beat
//
// One request beat per cycle while no response is held; its response appears
// in the output register on the next cycle. The key row is kept sorted,
// smallest in cell 0, and each beat shifts it by at most one place.
// Reset empties the row at once (cell valid bits only); no clearing pass.
// A response beat held by rsp_o.ready stalls req_i until it is taken.
module min_priority_queue (
  input logic       clk_i,
  input logic       rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o
);
  import mpq_pkg::*;

  mpq_link_t lnk [CAPACITY];
  mpq_cmd_t  cmd;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    rsp_valid_q;
  logic signed [KEY_W-1:0] rsp_key_q, rsp_key_d;
  status_e                 rsp_st_q, rsp_st_d;
  logic [CNT_W-1:0]        rsp_occ_q;

  logic acc, full, empty;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc   = req_i.valid && req_i.ready;
  assign full  = (cnt_q == CNT_W'(CAPACITY));
  assign empty = (cnt_q == '0);

  always_comb begin
    cmd.ins   = 1'b0;
    cmd.ext   = 1'b0;
    cmd.key   = req_i.key_in;
    cnt_d     = cnt_q;
    rsp_key_d = '0;
    rsp_st_d  = ST_OK;
    case (req_i.func)
      FN_INSERT: begin
        if (full) begin
          rsp_st_d = ST_FULL;
        end else begin
          cmd.ins = acc;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      FN_FIND, FN_EXTRACT: begin
        if (empty) begin
          rsp_key_d = EMPTY_KEY;
          rsp_st_d  = ST_EMPTY;
        end else begin
          rsp_key_d = lnk[0].key;
          if (req_i.func == FN_EXTRACT) begin
            cmd.ext = acc;
            cnt_d   = cnt_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mpq_link_t prev, next;
    if (i == 0) begin : g_head
      assign prev = '{key: '0, vld: 1'b0, gt: 1'b0};
    end else begin : g_prev
      assign prev = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next = '{key: '0, vld: 1'b0, gt: 1'b0};
    end else begin : g_next
      assign next = lnk[i+1];
    end
    mpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .link_o (lnk[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        cnt_q <= cnt_d;
      end
      if (req_i.ready) begin
        rsp_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_key_q <= rsp_key_d;
      rsp_st_q  <= rsp_st_d;
      rsp_occ_q <= cnt_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.key_out   = rsp_key_q;
  assign rsp_o.status    = rsp_st_q;
  assign rsp_o.occupancy = OCC_W'(rsp_occ_q);

  logic [CAPACITY-1:0] vld_vec;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_vld
    assign vld_vec[i] = lnk[i].vld;
  end

  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == cnt_q)
    else $error("key count differs from number of occupied cells");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("occupied cells are not a contiguous prefix");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lnk[1].vld |-> !(lnk[1].key < lnk[0].key))
    else $error("head cell does not hold the minimum");

  a_extract_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_i.func == FN_EXTRACT && !empty) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("extract did not reduce the count");

endmodule
